[sv/bdws_pkg.sv]
package bdws_pkg;

	// Default geometry of the store.
	localparam int DEPTH_DEF      = 16;
	localparam int ITEM_WIDTH_DEF = 32;

	// Field widths fixed by the command and register formats.
	localparam int CMD_W   = 3;
	localparam int LIMIT_W = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// Per-cell control: load the incoming item, take the left neighbour,
	// take the right neighbour, or capture a search compare.
	typedef struct packed {
		logic load;
		logic shr;
		logic shl;
		logic capture;
	} cell_ctrl_t;

endpackage

[sv/bdws_cmd_if.sv]
interface bdws_cmd_if #(
	parameter int ITEM_WIDTH = bdws_pkg::ITEM_WIDTH_DEF
);
	logic                       valid;
	logic                       ready;
	logic [bdws_pkg::CMD_W-1:0] command;
	logic [ITEM_WIDTH-1:0]      item_value;

	modport source (output valid, output command, output item_value, input ready);
	modport sink   (input valid, input command, input item_value, output ready);
endinterface

[sv/bdws_res_if.sv]
interface bdws_res_if #(
	parameter int ITEM_WIDTH = bdws_pkg::ITEM_WIDTH_DEF,
	parameter int CNT_W      = $clog2(bdws_pkg::DEPTH_DEF + 1)
);
	logic                  valid;
	logic                  ready;
	logic                  ok;
	logic [ITEM_WIDTH-1:0] item_out;
	logic [CNT_W-1:0]      position;
	logic [CNT_W-1:0]      occupancy;

	modport source (output valid, output ok, output item_out, output position,
		output occupancy, input ready);
	modport sink   (input valid, input ok, input item_out, input position,
		input occupancy, output ready);
endinterface

[sv/bdws_cell.sv]
module bdws_cell #(
	parameter int ITEM_WIDTH = bdws_pkg::ITEM_WIDTH_DEF
) (
	input  logic                 clk,
	input  bdws_pkg::cell_ctrl_t ctrl,
	input  logic [ITEM_WIDTH-1:0] in_value,
	input  logic [ITEM_WIDTH-1:0] left_data,
	input  logic [ITEM_WIDTH-1:0] right_data,
	output logic [ITEM_WIDTH-1:0] data_q,
	output logic                  hit_q
);

	// Entry storage: no reset, an entry is only read once it has been written.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= in_value;
		end else if (ctrl.shr) begin
			data_q <= left_data;
		end else if (ctrl.shl) begin
			data_q <= right_data;
		end
	end

	// The search key arrives with the item; the compare result is kept for the scan.
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			hit_q <= (data_q == in_value);
		end
	end

endmodule

[sv/bounded_deque_with_search_core.sv]
// Bounded double-ended store with search. Items are kept in a row of cells
// with the front entry always in cell 0: a push at the front shifts the row
// one cell towards the back, a pop at the front shifts it one cell towards
// the front, a push at the back loads the cell at the current occupancy and
// a pop at the back reads the cell just below it. Push, pop and unknown
// commands are finished when accepted, so a new item can be accepted in
// every cycle while results are taken. A search first lets every cell
// compare its entry against the value in the cycle the item is accepted,
// then a scanner walks the stored hit flags one cell per cycle from the
// front; the block stays busy until the scan stops at the first match or at
// the occupancy. The result sits in an output register, so the next item is
// taken in the same cycle as the previous result is taken.
// The capacity register may be written at any time the block is idle; a
// limit above DEPTH behaves as DEPTH and a limit of zero refuses all pushes.
// There is no clearing pass after reset: only entries that are held are read.
module bounded_deque_with_search_core #(
	parameter int DEPTH      = bdws_pkg::DEPTH_DEF,
	parameter int ITEM_WIDTH = bdws_pkg::ITEM_WIDTH_DEF,
	parameter int CNT_W      = $clog2(DEPTH + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	bdws_cmd_if.sink                         cmd,
	bdws_res_if.source                       res,
	input  logic                             cfg_we,
	input  logic [bdws_pkg::LIMIT_W-1:0]     cfg_wdata
);

	// Width of a cell index, and of the compare between count and limit.
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W = (CNT_W > bdws_pkg::LIMIT_W) ? CNT_W : bdws_pkg::LIMIT_W;

	// Configuration register: the capacity limit.
	logic [bdws_pkg::LIMIT_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= bdws_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Control state.
	bdws_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] scan_q, scan_d;

	// Output register.
	logic                  out_valid_q;
	logic                  out_ok_q;
	logic [ITEM_WIDTH-1:0] out_item_q;
	logic [CNT_W-1:0]      out_pos_q;
	logic [CNT_W-1:0]      out_occ_q;

	// Result to be loaded into the output register this cycle.
	logic                  out_load;
	logic                  r_ok;
	logic [ITEM_WIDTH-1:0] r_item;
	logic [CNT_W-1:0]      r_pos;

	// Cell row.
	logic [ITEM_WIDTH-1:0] data_w [DEPTH];
	logic [DEPTH-1:0]      hit_w;

	logic             in_ready;
	logic             accept;
	logic             full;
	logic [CNT_W-1:0] count_m1;
	logic             push_back_go;
	logic             push_front_go;
	logic             pop_front_go;
	logic             search_go;

	// The block takes an item only when idle and the output register will be
	// free at the same edge.
	assign in_ready  = (state_q == bdws_pkg::ST_IDLE) && (!out_valid_q || res.ready);
	assign cmd.ready = in_ready;
	assign accept    = cmd.valid && in_ready;

	// Full once the count reaches either the configured limit or the depth.
	assign full = (CMP_W'(count_q) >= CMP_W'(limit_q)) || (count_q >= CNT_W'(DEPTH));
	assign count_m1 = count_q - CNT_W'(1);

	assign push_back_go  = accept && (cmd.command == bdws_pkg::CMD_PUSH_BACK) && !full;
	assign push_front_go = accept && (cmd.command == bdws_pkg::CMD_PUSH_FRONT) && !full;
	assign pop_front_go  = accept && (cmd.command == bdws_pkg::CMD_POP_FRONT)
		&& (count_q != '0);
	assign search_go     = accept && (cmd.command == bdws_pkg::CMD_SEARCH);

	// Each cell is told whether to load, shift or capture. A push at the back
	// loads the cell just past the last held entry; a push at the front loads
	// cell 0 while every other cell takes its left neighbour.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		bdws_pkg::cell_ctrl_t  ctrl;
		logic [ITEM_WIDTH-1:0] left_d;
		logic [ITEM_WIDTH-1:0] right_d;

		always_comb begin
			ctrl.load    = (push_back_go && (count_q == CNT_W'(i)))
				|| (push_front_go && (i == 0));
			ctrl.shr     = push_front_go && (i != 0);
			ctrl.shl     = pop_front_go;
			ctrl.capture = search_go;
		end

		if (i == 0) begin : g_first
			assign left_d = cmd.item_value;
		end else begin : g_mid
			assign left_d = data_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_d = data_w[i];
		end else begin : g_inner
			assign right_d = data_w[i+1];
		end

		bdws_cell #(
			.ITEM_WIDTH (ITEM_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.in_value   (cmd.item_value),
			.left_data  (left_d),
			.right_data (right_d),
			.data_q     (data_w[i]),
			.hit_q      (hit_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdws_pkg::ST_IDLE;
			count_q <= '0;
			scan_q  <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			scan_q  <= scan_d;
		end
	end

	// Next state and results. Push, pop and unknown-command results are formed
	// at once; a search moves to the scan, which checks one cell's hit flag per
	// cycle from the front and stops at the first hit or at the occupancy.
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		scan_d   = scan_q;
		out_load = 1'b0;
		r_ok     = 1'b0;
		r_item   = '0;
		r_pos    = '0;
		unique case (state_q)
			bdws_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd.command == bdws_pkg::CMD_SEARCH) begin
						state_d = bdws_pkg::ST_SCAN;
						scan_d  = '0;
					end else begin
						out_load = 1'b1;
						case (cmd.command)
							bdws_pkg::CMD_PUSH_BACK, bdws_pkg::CMD_PUSH_FRONT: begin
								if (!full) begin
									r_ok    = 1'b1;
									count_d = count_q + CNT_W'(1);
								end
							end
							bdws_pkg::CMD_POP_FRONT: begin
								if (count_q != '0) begin
									r_ok    = 1'b1;
									r_item  = data_w[0];
									count_d = count_m1;
								end
							end
							bdws_pkg::CMD_POP_BACK: begin
								if (count_q != '0) begin
									r_ok    = 1'b1;
									r_item  = data_w[count_m1[IDX_W-1:0]];
									count_d = count_m1;
								end
							end
							default: begin
								r_ok = 1'b0;
							end
						endcase
					end
				end
			end
			bdws_pkg::ST_SCAN: begin
				if (scan_q >= count_q) begin
					out_load = 1'b1;
					state_d  = bdws_pkg::ST_IDLE;
				end else if (hit_w[scan_q[IDX_W-1:0]]) begin
					out_load = 1'b1;
					r_ok     = 1'b1;
					r_pos    = scan_q + CNT_W'(1);
					state_d  = bdws_pkg::ST_IDLE;
				end else begin
					scan_d = scan_q + CNT_W'(1);
				end
			end
			default: begin
				state_d = bdws_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The occupancy reported is the count after the command.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ok_q   <= r_ok;
			out_item_q <= r_item;
			out_pos_q  <= r_pos;
			out_occ_q  <= count_d;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.ok        = out_ok_q;
	assign res.item_out  = out_item_q;
	assign res.position  = out_pos_q;
	assign res.occupancy = out_occ_q;

	// The count never goes past the physical depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	// No new item is taken while a search is being scanned.
	a_scan_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bdws_pkg::ST_SCAN) |-> !cmd.ready)
		else $error("item accepted during search scan");

	// The output register is empty for the whole scan, so the result can land.
	a_scan_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bdws_pkg::ST_SCAN) |-> !out_valid_q)
		else $error("output busy during search scan");

	// A successful push adds exactly one entry.
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push_back_go || push_front_go) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("push did not advance count");

endmodule
